// ===== rtl/cscan_pkg.sv =====
// Shared widths, register indexes and word types of the C-SCAN disk scheduler.
package cscan_pkg;

  localparam int TRACK_BITS           = 16;
  localparam int COUNT_BITS           = TRACK_BITS + 1;
  localparam int SEEK_BITS            = TRACK_BITS + 6;
  localparam int MAX_REQUESTS_DEFAULT = 32;

  // Configuration register indexes.
  localparam int CFG_INDEX_BITS = 1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_HEAD_START  = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_TRACK_COUNT = 1'b1;

  typedef struct packed {
    logic [TRACK_BITS-1:0] request_track;
    logic                  last_request;
  } req_word_t;

  typedef struct packed {
    logic [TRACK_BITS-1:0] served_track;
    logic [TRACK_BITS-1:0] move_distance;
    logic [SEEK_BITS-1:0]  seek_total;
    logic                  last_served;
  } res_word_t;

  // Command from the sequencer to the seek unit.
  typedef struct packed {
    logic                  start;
    logic [TRACK_BITS-1:0] head;
    logic                  valid;
    logic [TRACK_BITS-1:0] track;
    logic                  last;
  } emit_req_t;

endpackage

// ===== rtl/cscan_store.sv =====
// Request store: synchronous memory with one write port and one registered read port.
module cscan_store import cscan_pkg::*; #(
  parameter int DEPTH = MAX_REQUESTS_DEFAULT,
  parameter int AW    = 5
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AW-1:0]         waddr_i,
  input  logic [TRACK_BITS-1:0] wdata_i,
  input  logic                  re_i,
  input  logic [AW-1:0]         raddr_i,
  output logic [TRACK_BITS-1:0] rdata_o
);

  logic [TRACK_BITS-1:0] mem [DEPTH];
  logic [TRACK_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/cscan_emit.sv =====
// Seek unit: tracks the head, sums distances and holds the result word register.
module cscan_emit import cscan_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  emit_req_t req_i,
  output logic      ack_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output res_word_t out_data_o
);

  logic                  out_valid_q;
  res_word_t             out_q;
  logic [TRACK_BITS-1:0] head_q;
  logic [SEEK_BITS-1:0]  acc_q;
  logic [TRACK_BITS-1:0] move_dist;
  logic [SEEK_BITS-1:0]  acc_sum;

  assign ack_o     = req_i.valid && (!out_valid_q || !out_stall_i);
  assign move_dist = (req_i.track >= head_q) ? (req_i.track - head_q)
                                             : (head_q - req_i.track);
  assign acc_sum   = acc_q + SEEK_BITS'(move_dist);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      head_q      <= '0;
      acc_q       <= '0;
    end else begin
      if (req_i.start) begin
        head_q <= req_i.head;
        acc_q  <= '0;
      end else if (ack_o) begin
        head_q <= req_i.track;
        acc_q  <= acc_sum;
      end
      if (ack_o) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ack_o) begin
      out_q.served_track  <= req_i.track;
      out_q.move_distance <= move_dist;
      out_q.seek_total    <= acc_sum;
      out_q.last_served   <= req_i.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/cscan_seq.sv =====
// Sequencer: sorted insertion into the store and the two-sweep service walk.
module cscan_seq import cscan_pkg::*; #(
  parameter int MAX_REQUESTS = MAX_REQUESTS_DEFAULT,
  parameter int AW           = 5,
  parameter int CW           = 6
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  req_word_t             in_data_i,
  input  logic [TRACK_BITS-1:0] head_start_i,
  input  logic [COUNT_BITS-1:0] track_count_i,
  output logic                  we_o,
  output logic [AW-1:0]         waddr_o,
  output logic [TRACK_BITS-1:0] wdata_o,
  output logic                  re_o,
  output logic [AW-1:0]         raddr_o,
  input  logic [TRACK_BITS-1:0] rdata_i,
  output emit_req_t             req_o,
  input  logic                  ack_i
);

  typedef enum logic [9:0] {
    S_IDLE    = 10'b00_0000_0001,
    S_INS     = 10'b00_0000_0010,
    S_PLACE   = 10'b00_0000_0100,
    S_SRCH_RD = 10'b00_0000_1000,
    S_SRCH    = 10'b00_0001_0000,
    S_UP_RD   = 10'b00_0010_0000,
    S_UP      = 10'b00_0100_0000,
    S_ZERO    = 10'b00_1000_0000,
    S_LOW_RD  = 10'b01_0000_0000,
    S_LOW     = 10'b10_0000_0000
  } state_e;

  state_e                state_q, state_d;
  logic [CW-1:0]         count_q, count_d;
  logic [CW-1:0]         k_q, k_d;
  logic [CW-1:0]         idx_q, idx_d;
  logic [CW-1:0]         p_q, p_d;
  logic [TRACK_BITS-1:0] val_q, val_d;
  logic                  last_q, last_d;
  logic [TRACK_BITS-1:0] head_q, head_d;
  logic [TRACK_BITS-1:0] top_q, top_d;
  logic                  top_done_q, top_done_d;
  logic                  begin_batch;
  logic                  finish;
  logic [TRACK_BITS-1:0] top_calc;
  logic                  top_sat;

  // A track count of zero or beyond the track space saturates the top track.
  assign top_sat  = (track_count_i == '0) ||
                    (track_count_i[TRACK_BITS] && (|track_count_i[TRACK_BITS-1:0]));
  assign top_calc = top_sat ? '1 : TRACK_BITS'(track_count_i - COUNT_BITS'(1));

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    k_d         = k_q;
    idx_d       = idx_q;
    p_d         = p_q;
    val_d       = val_q;
    last_d      = last_q;
    head_d      = head_q;
    top_d       = top_q;
    top_done_d  = top_done_q;
    we_o        = 1'b0;
    waddr_o     = '0;
    wdata_o     = val_q;
    re_o        = 1'b0;
    raddr_o     = '0;
    req_o       = '0;
    begin_batch = 1'b0;
    finish      = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          val_d  = in_data_i.request_track;
          last_d = in_data_i.last_request;
          if (count_q < CW'(MAX_REQUESTS)) begin
            count_d = count_q + CW'(1);
            if (count_q == '0) begin
              we_o        = 1'b1;
              waddr_o     = '0;
              wdata_o     = in_data_i.request_track;
              begin_batch = in_data_i.last_request;
            end else begin
              re_o    = 1'b1;
              raddr_o = AW'(count_q - CW'(1));
              k_d     = count_q;
              state_d = S_INS;
            end
          end else begin
            begin_batch = in_data_i.last_request;
          end
        end
      end
      S_INS: begin
        // The entry below the open slot is larger: move it up one place.
        if (rdata_i > val_q) begin
          we_o    = 1'b1;
          waddr_o = AW'(k_q);
          wdata_o = rdata_i;
          k_d     = k_q - CW'(1);
          if (k_q == CW'(1)) begin
            state_d = S_PLACE;
          end else begin
            re_o    = 1'b1;
            raddr_o = AW'(k_q - CW'(2));
          end
        end else begin
          we_o    = 1'b1;
          waddr_o = AW'(k_q);
          wdata_o = val_q;
          finish  = 1'b1;
        end
      end
      S_PLACE: begin
        we_o    = 1'b1;
        waddr_o = '0;
        wdata_o = val_q;
        finish  = 1'b1;
      end
      S_SRCH_RD: begin
        if (idx_q == count_q) begin
          p_d     = count_q;
          state_d = S_UP_RD;
        end else begin
          re_o    = 1'b1;
          raddr_o = AW'(idx_q);
          state_d = S_SRCH;
        end
      end
      S_SRCH: begin
        if (rdata_i >= head_q) begin
          p_d     = idx_q;
          state_d = S_UP;
        end else begin
          idx_d   = idx_q + CW'(1);
          state_d = S_SRCH_RD;
        end
      end
      S_UP_RD: begin
        if (idx_q == count_q) begin
          if (top_done_q) begin
            state_d = S_ZERO;
          end else begin
            req_o.valid = 1'b1;
            req_o.track = top_q;
            if (ack_i) begin
              top_done_d = 1'b1;
              state_d    = S_ZERO;
            end
          end
        end else begin
          re_o    = 1'b1;
          raddr_o = AW'(idx_q);
          state_d = S_UP;
        end
      end
      S_UP: begin
        req_o.valid = 1'b1;
        if (!top_done_q && (top_q <= rdata_i)) begin
          req_o.track = top_q;
          if (ack_i) begin
            top_done_d = 1'b1;
          end
        end else begin
          req_o.track = rdata_i;
          if (ack_i) begin
            idx_d   = idx_q + CW'(1);
            state_d = S_UP_RD;
          end
        end
      end
      S_ZERO: begin
        req_o.valid = 1'b1;
        req_o.track = '0;
        req_o.last  = (p_q == '0);
        if (ack_i) begin
          idx_d = '0;
          if (p_q == '0) begin
            count_d = '0;
            state_d = S_IDLE;
          end else begin
            state_d = S_LOW_RD;
          end
        end
      end
      S_LOW_RD: begin
        re_o    = 1'b1;
        raddr_o = AW'(idx_q);
        state_d = S_LOW;
      end
      S_LOW: begin
        req_o.valid = 1'b1;
        req_o.track = rdata_i;
        req_o.last  = ((idx_q + CW'(1)) == p_q);
        if (ack_i) begin
          idx_d = idx_q + CW'(1);
          if ((idx_q + CW'(1)) == p_q) begin
            count_d = '0;
            state_d = S_IDLE;
          end else begin
            state_d = S_LOW_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (finish) begin
      if (last_q) begin
        begin_batch = 1'b1;
      end else begin
        state_d = S_IDLE;
      end
    end

    // The batch head and top track are captured from the configuration when the batch begins.
    if (begin_batch) begin
      state_d    = S_SRCH_RD;
      idx_d      = '0;
      top_done_d = 1'b0;
      head_d     = head_start_i;
      top_d      = top_calc;
      req_o.start = 1'b1;
      req_o.head  = head_start_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count_q    <= '0;
      k_q        <= '0;
      idx_q      <= '0;
      p_q        <= '0;
      last_q     <= 1'b0;
      top_done_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      k_q        <= k_d;
      idx_q      <= idx_d;
      p_q        <= p_d;
      last_q     <= last_d;
      top_done_q <= top_done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    head_q <= head_d;
    top_q  <= top_d;
  end

endmodule

// ===== rtl/cscan_disk_scheduler.sv =====
// C-SCAN disk scheduler top level: configuration registers, sequencer, store and seek unit.
// A request without the last flag is sorted into the store by an insert that walks the stored
// entries one per cycle through the store's read port, n being the number of stored requests.
// A last request is followed by a search for the first entry at or above the head and then n+2
// result words, one store read per stored request; output stalls stretch that phase.
// Reset clears the batch, sets head_start to 0 and track_count to 2^TRACK_BITS.
module cscan_disk_scheduler import cscan_pkg::*; #(
  parameter int MAX_REQUESTS = MAX_REQUESTS_DEFAULT
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  req_word_t                 in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output res_word_t                 out_data_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic [COUNT_BITS-1:0]     cfg_data_i
);

  // Store address width and a count width that can also hold the full depth.
  localparam int AW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int CW = $clog2(MAX_REQUESTS + 1);

  logic [TRACK_BITS-1:0] head_start_q;
  logic [COUNT_BITS-1:0] track_count_q;

  logic                  we;
  logic [AW-1:0]         waddr;
  logic [TRACK_BITS-1:0] wdata;
  logic                  re;
  logic [AW-1:0]         raddr;
  logic [TRACK_BITS-1:0] rdata;
  emit_req_t             emit_req;
  logic                  emit_ack;

  // Configuration words are taken whenever the sequencer is idle.
  assign cfg_ready_o = !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_start_q  <= '0;
      track_count_q <= COUNT_BITS'(1) << TRACK_BITS;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_HEAD_START:  head_start_q  <= cfg_data_i[TRACK_BITS-1:0];
        CFG_TRACK_COUNT: track_count_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // The sequencer keeps the store sorted in ascending order as requests arrive,
  // then walks it: up sweep from the first entry at or above the head, with the
  // top track merged in, then track 0 and the entries below the head.
  cscan_seq #(
    .MAX_REQUESTS(MAX_REQUESTS),
    .AW          (AW),
    .CW          (CW)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .head_start_i (head_start_q),
    .track_count_i(track_count_q),
    .we_o         (we),
    .waddr_o      (waddr),
    .wdata_o      (wdata),
    .re_o         (re),
    .raddr_o      (raddr),
    .rdata_i      (rdata),
    .req_o        (emit_req),
    .ack_i        (emit_ack)
  );

  cscan_store #(
    .DEPTH(MAX_REQUESTS),
    .AW   (AW)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // The seek unit owns the head position and the running total, and its output
  // register lets a finished word wait while the sequencer moves on.
  cscan_emit u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (emit_req),
    .ack_o      (emit_ack),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule
